// File: sv/host_interface_word_port_unit_defines.svh
// ---------------------------------------------------------------------------
// host interface word port - assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ---------------------------------------------------------------------------
`ifndef HOST_INTERFACE_WORD_PORT_UNIT_DEFINES_SVH
`define HOST_INTERFACE_WORD_PORT_UNIT_DEFINES_SVH

// property holds at every edge outside reset
`define HIWP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define HIWP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: sv/hiwp_pkg.sv
// ---------------------------------------------------------------------------
// hiwp_pkg
// types, register codes and constants of the host interface word port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hiwp_pkg;

  // item opcodes as they arrive on the input channel
  typedef enum logic [2:0] {
    OPC_READ  = 3'd0,
    OPC_WRITE = 3'd1,
    OPC_PUSH  = 3'd2,
    OPC_CLEAR = 3'd3,
    OPC_TICK  = 3'd4
  } opcode_e;

  // classified work for the back end
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_READ,
    KIND_WRITE,
    KIND_PUSH,
    KIND_CLEAR,
    KIND_TICK
  } kind_e;

  // host register map
  typedef enum logic [2:0] {
    REG_ICR    = 3'd0,
    REG_CVR    = 3'd1,
    REG_ISR    = 3'd2,
    REG_IVR    = 3'd3,
    REG_UNUSED = 3'd4,
    REG_TXH    = 3'd5,
    REG_TXM    = 3'd6,
    REG_TXL    = 3'd7
  } reg_addr_e;

  typedef struct packed {
    kind_e       kind;
    reg_addr_e   addr;
    logic [7:0]  bus_data;
    logic [23:0] partner_word;
    logic [15:0] tick_cycles;
  } cmd_t;

  localparam int unsigned ICR_HLEND_BIT = 5;
  localparam int unsigned ICR_INIT_BIT  = 7;
  localparam int unsigned CVR_HC_BIT    = 7;
  localparam int unsigned ISR_RXDF_BIT  = 0;

  localparam logic [7:0]  IVR_RESET           = 8'h0f;
  localparam logic [15:0] TIMEOUT_LIMIT_RESET = 16'd50;
  localparam logic [15:0] TIMEOUT_SAT         = 16'hffff;
  localparam int unsigned RX_DEPTH_DEFAULT    = 16;

endpackage

// File: sv/hiwp_ram.sv
// ---------------------------------------------------------------------------
// hiwp_ram
// generic single write, single read memory with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hiwp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // read returns the old contents on an address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/hiwp_front.sv
// ---------------------------------------------------------------------------
// hiwp_front
// accepts items, classifies them and holds them in a two entry queue
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hiwp_front
  import hiwp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [2:0]  reg_addr_i,
  input  logic [7:0]  bus_data_i,
  input  logic [23:0] partner_word_i,
  input  logic [15:0] tick_cycles_i,
  output logic        cmd_valid_o,
  input  logic        cmd_pop_i,
  output cmd_t        cmd_o
);

  `include "host_interface_word_port_unit_defines.svh"

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  cmd_t       cmd_new;

  always_comb begin
    cmd_new.addr         = reg_addr_e'(reg_addr_i);
    cmd_new.bus_data     = bus_data_i;
    cmd_new.partner_word = partner_word_i;
    cmd_new.tick_cycles  = tick_cycles_i;
    case (opcode_i)
      OPC_READ:  cmd_new.kind = KIND_READ;
      OPC_WRITE: cmd_new.kind = KIND_WRITE;
      OPC_PUSH:  cmd_new.kind = KIND_PUSH;
      OPC_CLEAR: cmd_new.kind = KIND_CLEAR;
      OPC_TICK:  cmd_new.kind = KIND_TICK;
      default:   cmd_new.kind = KIND_NONE;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

  `HIWP_ASSERT(a_queue_bound, cnt_q <= 2'd2, "item queue holds more than two items")
  `HIWP_ASSERT(a_pop_nonempty, cmd_pop_i |-> cnt_q != 2'd0, "item popped from empty queue")
  `HIWP_ASSERT_NEXT(a_full_stays, cnt_q == 2'd2 && !cmd_pop_i, cnt_q == 2'd2,
                    "full queue lost an item without a pop")

endmodule

// File: sv/hiwp_back.sv
// ---------------------------------------------------------------------------
// hiwp_back
// executes one classified item per unstalled cycle: host registers, transmit
// assembly, receive fifo and holding register, timeout, result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hiwp_back
  import hiwp_pkg::*;
#(
  parameter int unsigned RX_DEPTH = RX_DEPTH_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [15:0]                     timeout_limit_i,
  input  logic                            cmd_valid_i,
  output logic                            cmd_pop_o,
  input  cmd_t                            cmd_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      read_data_o,
  output logic                            tx_valid_o,
  output logic [23:0]                     tx_word_o,
  output logic                            irq_valid_o,
  output logic [7:0]                      irq_vector_o,
  output logic                            init_pulse_o,
  output logic                            data_wanted_o,
  output logic                            rx_overflow_o,
  output logic                            rx_full_flag_o,
  output logic [$clog2(RX_DEPTH+1)-1:0]   rx_level_o
);

  `include "host_interface_word_port_unit_defines.svh"

  localparam int unsigned AW = $clog2(RX_DEPTH);
  localparam int unsigned CW = $clog2(RX_DEPTH + 1);
  localparam logic [CW-1:0] CntFull = CW'(RX_DEPTH);
  localparam logic [AW-1:0] IdxLast = AW'(RX_DEPTH - 1);

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
    idx_inc = (idx == IdxLast) ? '0 : idx + 1'b1;
  endfunction

  // architectural state
  logic [7:0]    ctrl_q, ctrl_d;
  logic [7:0]    status_q, status_d;
  logic [7:0]    vector_q, vector_d;
  logic [7:0]    ivr_q, ivr_d;
  logic [7:0]    txh_q, txh_d, txm_q, txm_d;
  logic [23:0]   hold_q, hold_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [15:0]   tmo_q, tmo_d;

  // head word read path
  logic [23:0]   ram_rdata;
  logic [23:0]   head_word;
  logic          byp_q;
  logic [23:0]   byp_data_q;
  logic          ram_we;

  // per item results
  logic [7:0]    rd_res;
  logic          txv_res, irqv_res, initp_res, want_res, ovf_res;
  logic [23:0]   txw_res;
  logic [7:0]    irqw_res;

  logic          go;
  logic          le, rxdf;
  logic          load_req, pop, push, clr;
  logic [7:0]    rx_byte;
  logic          first_byte, last_byte;
  logic [16:0]   tmo_sum;
  logic [15:0]   tmo_sat;

  // output register
  logic          out_valid_q;
  logic [7:0]    rd_q;
  logic          txv_q, irqv_q, initp_q, want_q, ovf_q, rxdf_q;
  logic [23:0]   txw_q;
  logic [7:0]    irqw_q;
  logic [CW-1:0] lvl_q;

  assign go        = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign cmd_pop_o = go;
  assign le        = ctrl_q[ICR_HLEND_BIT];
  assign rxdf      = status_q[ISR_RXDF_BIT];
  assign head_word = byp_q ? byp_data_q : ram_rdata;

  // byte lane of the held word, per endian mode
  always_comb begin
    case (cmd_i.addr)
      REG_TXH: begin
        rx_byte    = le ? hold_q[7:0] : hold_q[23:16];
        first_byte = !le;
        last_byte  = le;
      end
      REG_TXM: begin
        rx_byte    = hold_q[15:8];
        first_byte = 1'b0;
        last_byte  = 1'b0;
      end
      REG_TXL: begin
        rx_byte    = le ? hold_q[23:16] : hold_q[7:0];
        first_byte = le;
        last_byte  = !le;
      end
      default: begin
        rx_byte    = 8'd0;
        first_byte = 1'b0;
        last_byte  = 1'b0;
      end
    endcase
  end

  assign tmo_sum = {1'b0, tmo_q} + {1'b0, cmd_i.tick_cycles};
  assign tmo_sat = tmo_sum[16] ? TIMEOUT_SAT : tmo_sum[15:0];

  always_comb begin
    ctrl_d    = ctrl_q;
    status_d  = status_q;
    vector_d  = vector_q;
    ivr_d     = ivr_q;
    txh_d     = txh_q;
    txm_d     = txm_q;
    hold_d    = hold_q;
    tmo_d     = tmo_q;
    rd_res    = 8'd0;
    txv_res   = 1'b0;
    txw_res   = 24'd0;
    irqv_res  = 1'b0;
    irqw_res  = 8'd0;
    initp_res = 1'b0;
    want_res  = 1'b0;
    ovf_res   = 1'b0;
    load_req  = 1'b0;
    push      = 1'b0;
    clr       = 1'b0;

    case (cmd_i.kind)
      KIND_READ: begin
        case (cmd_i.addr)
          REG_ICR: rd_res = ctrl_q;
          REG_CVR: rd_res = vector_q;
          REG_ISR: rd_res = status_q;
          REG_IVR: rd_res = ivr_q;
          REG_TXH, REG_TXM, REG_TXL: begin
            if (!rxdf) begin
              want_res = first_byte;
            end else begin
              rd_res = rx_byte;
              if (last_byte) begin
                status_d[ISR_RXDF_BIT] = 1'b0;
                load_req = 1'b1;
              end
            end
          end
          default: rd_res = 8'd0;
        endcase
      end
      KIND_WRITE: begin
        case (cmd_i.addr)
          REG_ICR: begin
            ctrl_d    = cmd_i.bus_data;
            initp_res = cmd_i.bus_data[ICR_INIT_BIT];
          end
          REG_CVR: begin
            vector_d = cmd_i.bus_data;
            if (cmd_i.bus_data[CVR_HC_BIT]) begin
              irqv_res = 1'b1;
              irqw_res = {cmd_i.bus_data[6:0], 1'b0};
              vector_d[CVR_HC_BIT] = 1'b0;
            end
          end
          REG_ISR: status_d = cmd_i.bus_data;
          REG_IVR: ivr_d = cmd_i.bus_data;
          REG_TXH: txh_d = cmd_i.bus_data;
          REG_TXM: txm_d = cmd_i.bus_data;
          REG_TXL: begin
            txv_res = 1'b1;
            txw_res = le ? {cmd_i.bus_data, txm_q, txh_q}
                         : {txh_q, txm_q, cmd_i.bus_data};
            txh_d   = 8'd0;
            txm_d   = 8'd0;
          end
          default: ;
        endcase
      end
      KIND_PUSH: begin
        if (!rxdf) begin
          if (cnt_q != '0) begin
            // head moves to the holding register, new word queues behind
            load_req = 1'b1;
            push     = 1'b1;
          end else begin
            // empty queue: word goes straight to the holding register
            hold_d = cmd_i.partner_word;
            status_d[ISR_RXDF_BIT] = 1'b1;
            tmo_d  = 16'd0;
          end
        end else if (cnt_q == CntFull) begin
          ovf_res = 1'b1;
        end else begin
          push = 1'b1;
        end
      end
      KIND_CLEAR: begin
        clr = 1'b1;
        status_d[ISR_RXDF_BIT] = 1'b0;
      end
      KIND_TICK: begin
        if (rxdf && cnt_q != '0) begin
          tmo_d = tmo_sat;
          if (tmo_sat >= timeout_limit_i) begin
            status_d[ISR_RXDF_BIT] = 1'b0;
            load_req = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // load next queued word into the holding register
    pop = load_req && (cnt_q != '0);
    if (pop) begin
      hold_d = head_word;
      status_d[ISR_RXDF_BIT] = 1'b1;
      tmo_d  = 16'd0;
    end

    head_d = (go && pop) ? idx_inc(head_q) : head_q;
    if (clr) begin
      tail_d = head_q;
      cnt_d  = '0;
    end else begin
      tail_d = push ? idx_inc(tail_q) : tail_q;
      cnt_d  = cnt_q + CW'(push) - CW'(pop);
    end
  end

  assign ram_we = go && push;

  hiwp_ram #(
    .Width (24),
    .Depth (RX_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (cmd_i.partner_word),
    .raddr_i (head_d),
    .rdata_o (ram_rdata)
  );

  // a write landing on the address being read is forwarded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= ram_we && (tail_q == head_d);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= cmd_i.partner_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q   <= 8'd0;
      status_q <= 8'd0;
      vector_q <= 8'd0;
      ivr_q    <= IVR_RESET;
      txh_q    <= 8'd0;
      txm_q    <= 8'd0;
      hold_q   <= 24'd0;
      head_q   <= '0;
      tail_q   <= '0;
      cnt_q    <= '0;
      tmo_q    <= 16'd0;
    end else if (go) begin
      ctrl_q   <= ctrl_d;
      status_q <= status_d;
      vector_q <= vector_d;
      ivr_q    <= ivr_d;
      txh_q    <= txh_d;
      txm_q    <= txm_d;
      hold_q   <= hold_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
      tmo_q    <= tmo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      rd_q    <= rd_res;
      txv_q   <= txv_res;
      txw_q   <= txw_res;
      irqv_q  <= irqv_res;
      irqw_q  <= irqw_res;
      initp_q <= initp_res;
      want_q  <= want_res;
      ovf_q   <= ovf_res;
      rxdf_q  <= status_d[ISR_RXDF_BIT];
      lvl_q   <= cnt_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = rd_q;
  assign tx_valid_o     = txv_q;
  assign tx_word_o      = txw_q;
  assign irq_valid_o    = irqv_q;
  assign irq_vector_o   = irqw_q;
  assign init_pulse_o   = initp_q;
  assign data_wanted_o  = want_q;
  assign rx_overflow_o  = ovf_q;
  assign rx_full_flag_o = rxdf_q;
  assign rx_level_o     = lvl_q;

  `HIWP_ASSERT(a_cnt_bound, cnt_q <= CntFull, "receive fifo count above depth")
  `HIWP_ASSERT(a_ovf_full, out_valid_q && ovf_q |-> rxdf_q && lvl_q == CntFull,
               "overflow flagged without full fifo and held word")
  `HIWP_ASSERT(a_one_event, out_valid_q |-> !(txv_q && irqv_q),
               "transmit word and vector request in one result")
  `HIWP_ASSERT_NEXT(a_ptr_track, go && !clr, tail_q == ((head_q + AW'(cnt_q)) % RX_DEPTH),
                    "fifo tail does not match head plus count")

endmodule

// File: sv/host_interface_word_port_unit.sv
// ---------------------------------------------------------------------------
// host_interface_word_port_unit
// host side byte register port of a 24-bit word link with receive fifo
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// Every accepted item yields exactly one result item, in order. The block
// takes one item per clock when the result side keeps up: an item is
// decoded into a two entry queue at acceptance, the execute stage retires
// one queued item per cycle, and its result appears in the output register
// on the following edge. The execute stage keeps its receive fifo in a
// memory with registered read; the next head word is always prefetched,
// so pops never stall. A stalled result holds the output register while
// up to two more items are still taken. The fifo memory needs no clearing
// after reset. The timeout limit is written through cfg_we_i / cfg_wdata_i
// and resets to 50; the user must write it only while the block is idle,
// which the block itself does not enforce.
module host_interface_word_port_unit
  import hiwp_pkg::*;
#(
  parameter int unsigned RX_DEPTH = RX_DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // timeout limit register
  input  logic                          cfg_we_i,
  input  logic [15:0]                   cfg_wdata_i,
  // item input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    opcode_i,
  input  logic [2:0]                    reg_addr_i,
  input  logic [7:0]                    bus_data_i,
  input  logic [23:0]                   partner_word_i,
  input  logic [15:0]                   tick_cycles_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    read_data_o,
  output logic                          tx_valid_o,
  output logic [23:0]                   tx_word_o,
  output logic                          irq_valid_o,
  output logic [7:0]                    irq_vector_o,
  output logic                          init_pulse_o,
  output logic                          data_wanted_o,
  output logic                          rx_overflow_o,
  output logic                          rx_full_flag_o,
  output logic [$clog2(RX_DEPTH+1)-1:0] rx_level_o
);

  logic [15:0] limit_q;
  logic        cmd_valid;
  logic        cmd_pop;
  cmd_t        cmd;

  // timeout limit, to be changed only while idle; the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= TIMEOUT_LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // front: handshake, opcode classification, item queue
  hiwp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .reg_addr_i     (reg_addr_i),
    .bus_data_i     (bus_data_i),
    .partner_word_i (partner_word_i),
    .tick_cycles_i  (tick_cycles_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_pop_i      (cmd_pop),
    .cmd_o          (cmd)
  );

  // back: register file, transmit assembly, receive path, result register
  hiwp_back #(
    .RX_DEPTH (RX_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .timeout_limit_i (limit_q),
    .cmd_valid_i     (cmd_valid),
    .cmd_pop_o       (cmd_pop),
    .cmd_i           (cmd),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .read_data_o     (read_data_o),
    .tx_valid_o      (tx_valid_o),
    .tx_word_o       (tx_word_o),
    .irq_valid_o     (irq_valid_o),
    .irq_vector_o    (irq_vector_o),
    .init_pulse_o    (init_pulse_o),
    .data_wanted_o   (data_wanted_o),
    .rx_overflow_o   (rx_overflow_o),
    .rx_full_flag_o  (rx_full_flag_o),
    .rx_level_o      (rx_level_o)
  );

endmodule

// File: sim/tb.sv
// ---------------------------------------------------------------------------
// tb - host interface word port testbench
// drives bus reads and writes, partner pushes, receive clears and ticks into
// the port, predicts each result item in step and checks every field
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import hiwp_pkg::*;

  // run ends here whatever state the port is in
  localparam int unsigned CYCLE_LIMIT = 200000;
  // long receiver hold-off so the port fills and stalls its input
  localparam int unsigned LONG_HOLD_CYCLES = 200;
  // cycles allowed after the last result before the port counts as idle
  localparam int unsigned SETTLE_CYCLES = 4;

  // one input item as the sender offers it
  typedef struct {
    logic [2:0]  opcode;
    logic [2:0]  addr;
    logic [7:0]  data;
    logic [23:0] word;
    logic [15:0] ticks;
    bit          drain_first;  // sender waits until all results are back
  } port_item_t;

  // one result item, field for field as the port returns it
  typedef struct packed {
    logic [7:0]  read_data;
    logic        tx_valid;
    logic [23:0] tx_word;
    logic        irq_valid;
    logic [7:0]  irq_vector;
    logic        init_pulse;
    logic        data_wanted;
    logic        rx_overflow;
    logic        rx_full_flag;
    logic [4:0]  rx_level;
  } port_result_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [15:0] cfg_wdata_i    = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [2:0]  opcode_i       = '0;
  logic [2:0]  reg_addr_i     = '0;
  logic [7:0]  bus_data_i     = '0;
  logic [23:0] partner_word_i = '0;
  logic [15:0] tick_cycles_i  = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [7:0]  read_data_o;
  logic        tx_valid_o;
  logic [23:0] tx_word_o;
  logic        irq_valid_o;
  logic [7:0]  irq_vector_o;
  logic        init_pulse_o;
  logic        data_wanted_o;
  logic        rx_overflow_o;
  logic        rx_full_flag_o;
  logic [4:0]  rx_level_o;

  host_interface_word_port_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .reg_addr_i     (reg_addr_i),
    .bus_data_i     (bus_data_i),
    .partner_word_i (partner_word_i),
    .tick_cycles_i  (tick_cycles_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_data_o    (read_data_o),
    .tx_valid_o     (tx_valid_o),
    .tx_word_o      (tx_word_o),
    .irq_valid_o    (irq_valid_o),
    .irq_vector_o   (irq_vector_o),
    .init_pulse_o   (init_pulse_o),
    .data_wanted_o  (data_wanted_o),
    .rx_overflow_o  (rx_overflow_o),
    .rx_full_flag_o (rx_full_flag_o),
    .rx_level_o     (rx_level_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predicted port state, kept in step with accepted items
  // ---------------------------------------------------------------------------
  logic [7:0]  icr_q = '0;
  logic [7:0]  isr_q = '0;
  logic [7:0]  cvr_q = '0;
  logic [7:0]  ivr_q = IVR_RESET;
  logic [7:0]  tx_byte_q [3] = '{default: 8'h00};
  logic [23:0] rx_hold_q = '0;
  logic [23:0] rx_words [$];       // receive fifo, oldest word first
  int unsigned timeout_acc = 0;
  logic [15:0] timeout_limit = TIMEOUT_LIMIT_RESET;

  // stimulus and checking bookkeeping
  port_item_t   queued_bus_items [$];
  port_result_t awaited_port_results [$];
  port_item_t   offered_item;
  port_result_t oldest_result;
  int unsigned  mismatch_count = 0;
  int unsigned  useful_queued = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  long_holds_wanted = 0;
  int unsigned  long_holds_done = 0;
  int unsigned  hold_left = 0;
  int unsigned  cycle_count = 0;
  logic         gen_le = 1'b0;     // byte order the generated stream has set

  // holding register empty: take the oldest queued word, if any
  function automatic void load_next_rx_word();
    if (rx_words.size() == 0) return;
    timeout_acc = 0;
    rx_hold_q = rx_words[0];
    rx_words.delete(0);
    isr_q[ISR_RXDF_BIT] = 1'b1;
  endfunction

  function automatic port_result_t predict_port_result(port_item_t it);
    port_result_t r;
    logic le;
    int unsigned idx;
    r = '0;
    le = icr_q[ICR_HLEND_BIT];
    case (it.opcode)
      OPC_READ: begin
        case (it.addr)
          REG_ICR: r.read_data = icr_q;
          REG_CVR: r.read_data = cvr_q;
          REG_ISR: r.read_data = isr_q;
          REG_IVR: r.read_data = ivr_q;
          REG_TXH, REG_TXM, REG_TXL: begin
            idx = it.addr - REG_TXH;
            if (!isr_q[ISR_RXDF_BIT]) begin
              // empty holding register, only the first byte asks for data
              r.data_wanted = (idx == (le ? 2 : 0));
            end else begin
              r.read_data = 8'(rx_hold_q >> (le ? idx * 8 : (2 - idx) * 8));
              if (idx == (le ? 0 : 2)) begin
                isr_q[ISR_RXDF_BIT] = 1'b0;
                load_next_rx_word();
              end
            end
          end
          default: ;
        endcase
      end
      OPC_WRITE: begin
        case (it.addr)
          REG_ICR: begin
            icr_q = it.data;
            r.init_pulse = it.data[ICR_INIT_BIT];
          end
          REG_CVR: begin
            cvr_q = it.data;
            if (it.data[CVR_HC_BIT]) begin
              r.irq_valid = 1'b1;
              r.irq_vector = {it.data[6:0], 1'b0};
              cvr_q[CVR_HC_BIT] = 1'b0;
            end
          end
          REG_ISR: isr_q = it.data;
          REG_IVR: ivr_q = it.data;
          REG_TXH, REG_TXM: tx_byte_q[it.addr - REG_TXH] = it.data;
          REG_TXL: begin
            tx_byte_q[2] = it.data;
            r.tx_valid = 1'b1;
            r.tx_word = le ? {tx_byte_q[2], tx_byte_q[1], tx_byte_q[0]}
                           : {tx_byte_q[0], tx_byte_q[1], tx_byte_q[2]};
            tx_byte_q = '{default: 8'h00};
          end
          default: ;
        endcase
      end
      OPC_PUSH: begin
        if (!isr_q[ISR_RXDF_BIT]) begin
          load_next_rx_word();
          rx_words.insert(rx_words.size(), it.word);
          if (!isr_q[ISR_RXDF_BIT]) load_next_rx_word();
        end else if (rx_words.size() >= RX_DEPTH_DEFAULT) begin
          r.rx_overflow = 1'b1;
        end else begin
          rx_words.insert(rx_words.size(), it.word);
        end
      end
      OPC_CLEAR: begin
        rx_words.delete();
        isr_q[ISR_RXDF_BIT] = 1'b0;
      end
      OPC_TICK: begin
        // counts only while a word is held and more are queued behind it
        if (isr_q[ISR_RXDF_BIT] && rx_words.size() != 0) begin
          timeout_acc = timeout_acc + it.ticks;
          if (timeout_acc > TIMEOUT_SAT) timeout_acc = TIMEOUT_SAT;
          if (timeout_acc >= timeout_limit) begin
            isr_q[ISR_RXDF_BIT] = 1'b0;
            load_next_rx_word();
          end
        end
      end
      default: ;
    endcase
    r.rx_full_flag = isr_q[ISR_RXDF_BIT];
    r.rx_level = 5'(rx_words.size());
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // fields the opcode does not use still get random bits
  function automatic port_item_t mk_item(logic [2:0] op, logic [2:0] addr,
                                         logic [7:0] data);
    port_item_t it;
    it.opcode = op;
    it.addr = addr;
    it.data = data;
    it.word = 24'($urandom);
    it.ticks = 16'($urandom);
    it.drain_first = ($urandom_range(99) == 0);
    return it;
  endfunction

  function automatic void queue_item(port_item_t it);
    if (it.opcode == OPC_WRITE && it.addr == REG_ICR) gen_le = it.data[ICR_HLEND_BIT];
    if (it.opcode <= OPC_TICK) useful_queued++;
    queued_bus_items.insert(queued_bus_items.size(), it);
  endfunction

  // random traffic, mostly well-formed sequences with random content
  function automatic void queue_random_traffic(int unsigned n);
    int unsigned target;
    int unsigned pick;
    int unsigned cnt;
    port_item_t it;
    target = useful_queued + n;
    while (useful_queued < target) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        // partner words followed by host reads of them
        cnt = $urandom_range(1, 4);
        repeat (cnt)
          queue_item(mk_item(OPC_PUSH, 3'($urandom_range(7)), 8'($urandom)));
        repeat ($urandom_range(1, cnt)) begin
          if ($urandom_range(4) != 0) begin
            for (int k = 0; k < 3; k++)
              queue_item(mk_item(OPC_READ, 3'(gen_le ? REG_TXL - k : REG_TXH + k),
                                 8'($urandom)));
          end else begin
            repeat ($urandom_range(1, 3))
              queue_item(mk_item(OPC_READ, 3'($urandom_range(REG_TXH, REG_TXL)),
                                 8'($urandom)));
          end
        end
      end else if (pick < 45) begin
        // transmit word, now and then with a byte left out
        for (int k = REG_TXH; k <= REG_TXL; k++)
          if (k == REG_TXL || $urandom_range(5) != 0)
            queue_item(mk_item(OPC_WRITE, 3'(k), 8'($urandom)));
      end else if (pick < 55) begin
        queue_item(mk_item(OPC_WRITE, REG_CVR, 8'($urandom)));
        if ($urandom_range(1)) queue_item(mk_item(OPC_READ, REG_CVR, 8'($urandom)));
      end else if (pick < 63) begin
        queue_item(mk_item(OPC_WRITE, REG_ICR, 8'($urandom)));
        if ($urandom_range(1)) queue_item(mk_item(OPC_READ, REG_ICR, 8'($urandom)));
      end else if (pick < 73) begin
        repeat ($urandom_range(1, 3)) begin
          it = mk_item(OPC_TICK, 3'($urandom_range(7)), 8'($urandom));
          it.ticks = 16'(($urandom_range(9) == 0) ? $urandom_range(65535)
                                                  : $urandom_range(40));
          queue_item(it);
        end
      end else if (pick < 79) begin
        // burst that can fill the fifo and overflow it
        repeat ($urandom_range(10, 20))
          queue_item(mk_item(OPC_PUSH, 3'($urandom_range(7)), 8'($urandom)));
      end else if (pick < 83) begin
        queue_item(mk_item(OPC_CLEAR, 3'($urandom_range(7)), 8'($urandom)));
      end else if (pick < 89) begin
        queue_item(mk_item(3'($urandom_range(OPC_READ, OPC_WRITE)),
                           3'($urandom_range(REG_ISR, REG_UNUSED)), 8'($urandom)));
      end else if (pick < 96) begin
        queue_item(mk_item(OPC_READ, 3'($urandom_range(7)), 8'($urandom)));
      end else begin
        // noise: any opcode, including the unused ones
        queue_item(mk_item(3'($urandom_range(7)), 3'($urandom_range(7)), 8'($urandom)));
      end
    end
  endfunction

  // everything sent, every result back, then a settling wait
  task automatic wait_port_idle();
    while (queued_bus_items.size() != 0 || in_valid_i || awaited_port_results.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_timeout_limit(input logic [15:0] value);
    wait_port_idle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    timeout_limit = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued items, predicts each one when it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        awaited_port_results.insert(awaited_port_results.size(),
                                    predict_port_result(offered_item));
      end
      // a new item only once the offered one is gone
      if (!in_valid_i || in_ready_o) begin
        if (queued_bus_items.size() != 0 &&
            !(queued_bus_items[0].drain_first && awaited_port_results.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          offered_item = queued_bus_items[0];
          queued_bus_items.delete(0);
          in_valid_i <= 1'b1;
          opcode_i <= offered_item.opcode;
          reg_addr_i <= offered_item.addr;
          bus_data_i <= offered_item.data;
          partner_word_i <= offered_item.word;
          tick_cycles_i <= offered_item.ticks;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls plus an occasional long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (long_holds_done != long_holds_wanted) begin
        long_holds_done <= long_holds_wanted;
        hold_left <= LONG_HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: every taken result against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_port_results.size() == 0) begin
        $display("%0t: result item with none expected", $time);
        mismatch_count++;
      end else begin
        oldest_result = awaited_port_results[0];
        awaited_port_results.delete(0);
        check_field("read_data", oldest_result.read_data, read_data_o);
        check_field("tx_valid", oldest_result.tx_valid, tx_valid_o);
        check_field("tx_word", oldest_result.tx_word, tx_word_o);
        check_field("irq_valid", oldest_result.irq_valid, irq_valid_o);
        check_field("irq_vector", oldest_result.irq_vector, irq_vector_o);
        check_field("init_pulse", oldest_result.init_pulse, init_pulse_o);
        check_field("data_wanted", oldest_result.data_wanted, data_wanted_o);
        check_field("rx_overflow", oldest_result.rx_overflow, rx_overflow_o);
        check_field("rx_full_flag", oldest_result.rx_full_flag, rx_full_flag_o);
        check_field("rx_level", oldest_result.rx_level, rx_level_o);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of phases
  // ---------------------------------------------------------------------------
  initial begin
    port_item_t it;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, timeout limit still at its reset value
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_item(mk_item(OPC_READ, REG_TXH, 8'h00));      // empty, first byte: data wanted
    queue_item(mk_item(OPC_READ, REG_TXM, 8'h00));      // empty, not first byte
    queue_item(mk_item(OPC_READ, REG_IVR, 8'h00));      // reset value
    queue_item(mk_item(OPC_WRITE, REG_ICR, 8'h80));     // init pulse, big endian
    queue_item(mk_item(OPC_WRITE, REG_TXH, 8'hff));
    queue_item(mk_item(OPC_WRITE, REG_TXM, 8'h00));
    queue_item(mk_item(OPC_WRITE, REG_TXL, 8'ha5));     // emits the word
    queue_item(mk_item(OPC_WRITE, REG_CVR, 8'hff));     // host command, top vector
    queue_item(mk_item(OPC_READ, REG_CVR, 8'h00));      // command bit cleared
    it = mk_item(OPC_PUSH, REG_ICR, 8'h00);
    it.word = 24'hffffff;
    queue_item(it);
    it.word = 24'h000000;
    queue_item(it);
    it.word = 24'h123456;
    queue_item(it);
    it = mk_item(OPC_TICK, REG_ICR, 8'h00);
    it.ticks = 16'hffff;                                 // reaches the limit and skips the word
    queue_item(it);
    queue_item(mk_item(OPC_READ, REG_TXH, 8'h00));
    queue_item(mk_item(OPC_READ, REG_TXM, 8'h00));
    queue_item(mk_item(OPC_READ, REG_TXL, 8'h00));      // last byte, next word loaded
    queue_item(mk_item(OPC_WRITE, REG_ICR, 8'h20));     // little endian
    queue_item(mk_item(OPC_READ, REG_TXL, 8'h00));
    queue_item(mk_item(OPC_READ, REG_TXH, 8'h00));      // last byte in this order
    queue_item(mk_item(OPC_READ, REG_TXL, 8'h00));      // empty, first byte here
    queue_item(mk_item(OPC_WRITE, REG_UNUSED, 8'hff));  // ignored
    queue_item(mk_item(OPC_READ, REG_UNUSED, 8'h00));
    queue_item(mk_item(OPC_WRITE, REG_ISR, 8'h01));     // flag set by hand, no refill
    queue_item(mk_item(OPC_CLEAR, REG_ICR, 8'h00));
    queue_item(mk_item(OPC_WRITE, REG_ICR, 8'h00));

    // lowest limit, sender mostly busy, receiver often stalls
    write_timeout_limit(16'd1);
    send_idle_pct = 6;
    recv_idle_pct = 47;
    queue_random_traffic(400);

    // highest limit; receiver holds off while pushes pile up, then a drained read
    write_timeout_limit(16'hffff);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_holds_wanted++;
    queue_item(mk_item(OPC_WRITE, REG_ICR, 8'h00));
    repeat (20) queue_item(mk_item(OPC_PUSH, 3'($urandom_range(7)), 8'($urandom)));
    it = mk_item(OPC_READ, REG_TXH, 8'h00);
    it.drain_first = 1'b1;
    queue_item(it);
    queue_item(mk_item(OPC_READ, REG_TXM, 8'h00));
    queue_item(mk_item(OPC_READ, REG_TXL, 8'h00));
    it = mk_item(OPC_TICK, REG_ICR, 8'h00);
    it.ticks = 16'hffff;
    queue_item(it);
    for (int k = REG_TXH; k <= REG_TXL; k++) queue_item(mk_item(OPC_READ, 3'(k), 8'h00));
    queue_item(mk_item(OPC_CLEAR, REG_ICR, 8'h00));

    // middling limit, sender often idle, receiver mostly ready
    write_timeout_limit(16'($urandom_range(2, 200)));
    send_idle_pct = 47;
    recv_idle_pct = 6;
    queue_random_traffic(400);

    // reset value again, both sides flat out
    write_timeout_limit(TIMEOUT_LIMIT_RESET);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_traffic(400);

    wait_port_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
